// ===== rtl/closest_point_on_edge_set_core_defines.svh =====
// Assertion macros for the closest-point core.
// Bodies refer to clk and rst_n of the module that includes this header.
`ifndef CLOSEST_POINT_ON_EDGE_SET_CORE_DEFINES_SVH
`define CLOSEST_POINT_ON_EDGE_SET_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CPES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CPES_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cpes_pkg.sv =====
// Shared widths, types and helpers of the closest-point core.
// No dependencies; used by the channel interfaces and the top level.
package cpes_pkg;

    localparam int COORD_W   = 16;                 // signed coordinate
    localparam int MAG_W     = COORD_W;            // magnitude of a coordinate difference
    localparam int LEN_W     = 2 * MAG_W + 1;      // squared length, dot magnitude
    localparam int DOT_W     = LEN_W + 2;          // signed dot product
    localparam int DIST_W    = 2 * COORD_W + 2;    // squared distance
    localparam int PR_W      = LEN_W + MAG_W + 1;  // product / remainder-quotient shifter
    localparam int HI_W      = PR_W - MAG_W;       // upper part of the shifter
    localparam int CNT_W     = $clog2(MAG_W + 1);
    localparam int LANES     = 2;                  // lane 0 is x, lane 1 is y
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SEED_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_Y = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [DIST_W-1:0]         dist_t;

    // |x - y|; always fits MAG_W bits for two COORD_W-bit operands
    function automatic mag_t abs_diff(coord_t x, coord_t y);
        logic signed [COORD_W:0] diff;
        logic [COORD_W:0]        mag;
        diff = $signed({x[COORD_W-1], x}) - $signed({y[COORD_W-1], y});
        mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
        return mag[MAG_W-1:0];
    endfunction

endpackage

// ===== rtl/cpes_ifs.sv =====
// Valid/ready channel interfaces of the closest-point core.
// Depends on cpes_pkg for coordinate and distance types.
interface cpes_query_if import cpes_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t query_x;
    coord_t query_y;
    coord_t edge_start_x;
    coord_t edge_start_y;
    coord_t edge_end_x;
    coord_t edge_end_y;
    logic   edge_present;
    logic   first_edge;
    logic   last_edge;

    modport source (
        output valid, query_x, query_y, edge_start_x, edge_start_y,
               edge_end_x, edge_end_y, edge_present, first_edge, last_edge,
        input  ready
    );
    modport sink (
        input  valid, query_x, query_y, edge_start_x, edge_start_y,
               edge_end_x, edge_end_y, edge_present, first_edge, last_edge,
        output ready
    );
endinterface

interface cpes_result_if import cpes_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t closest_x;
    coord_t closest_y;
    dist_t  min_dist_sq;

    modport source (output valid, closest_x, closest_y, min_dist_sq, input ready);
    modport sink   (input valid, closest_x, closest_y, min_dist_sq, output ready);
endinterface

// ===== rtl/closest_point_on_edge_set_core.sv =====
// Closest point of a streamed 2D edge set to a query point, Q8.8 coordinates.
// Depends on cpes_pkg, cpes_ifs and closest_point_on_edge_set_core_defines.svh.
//
//   channel  | dir | payload                                   | accepted when
//   ---------+-----+-------------------------------------------+----------------------
//   query    | in  | query point, edge a->b, present/first/last | valid & ready
//   result   | out | closest_x, closest_y, min_dist_sq          | valid & ready
//   cfg      | in  | seed_x (index 0), seed_y (index 1)         | cfg_write
//
// Two bit-serial lanes (x and y) each run a shift-add multiplier that turns into a
// restoring divider. An item with neither edge nor restart runs no lane pass; a
// restart plus an edge whose projection falls inside it runs six lane passes and
// five control steps.
// query.ready is high only in idle; a waiting result does not block the next item
// unless that item is also the last of its query. Reset clears seeds and best point.
`include "closest_point_on_edge_set_core_defines.svh"

module closest_point_on_edge_set_core import cpes_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    cpes_query_if.sink           query,
    cpes_result_if.source        result
);

    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
    localparam logic [STATE_W-1:0] S_START  = 4'd1;
    localparam logic [STATE_W-1:0] S_SEED   = 4'd2;
    localparam logic [STATE_W-1:0] S_LEN    = 4'd3;
    localparam logic [STATE_W-1:0] S_DOT    = 4'd4;
    localparam logic [STATE_W-1:0] S_CHOOSE = 4'd5;
    localparam logic [STATE_W-1:0] S_PROJ   = 4'd6;
    localparam logic [STATE_W-1:0] S_DIV    = 4'd7;
    localparam logic [STATE_W-1:0] S_CAND   = 4'd8;
    localparam logic [STATE_W-1:0] S_DIST   = 4'd9;
    localparam logic [STATE_W-1:0] S_FIN    = 4'd10;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_SEED = 3'd1;
    localparam logic [OP_W-1:0] OP_LEN  = 3'd2;
    localparam logic [OP_W-1:0] OP_DOT  = 3'd3;
    localparam logic [OP_W-1:0] OP_PROJ = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd5;
    localparam logic [OP_W-1:0] OP_DIST = 3'd6;

    // control and architectural state
    logic [STATE_W-1:0] state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               div_reg, div_next;
    logic               out_valid_reg, out_valid_next;
    coord_t             seed_reg [LANES];
    coord_t             seed_next [LANES];
    coord_t             best_reg [LANES];
    coord_t             best_next [LANES];
    dist_t              best_dist_reg, best_dist_next;

    // item and datapath registers
    coord_t             q_reg [LANES];
    coord_t             q_next [LANES];
    coord_t             a_reg [LANES];
    coord_t             a_next [LANES];
    coord_t             b_reg [LANES];
    coord_t             b_next [LANES];
    coord_t             cand_reg [LANES];
    coord_t             cand_next [LANES];
    logic               present_reg, present_next;
    logic               first_reg, first_next;
    logic               last_reg, last_next;
    logic [LEN_W-1:0]   len2_reg, len2_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [LEN_W-1:0]   opa_reg [LANES];
    logic [LEN_W-1:0]   opa_next [LANES];
    logic [PR_W-1:0]    pr_reg [LANES];
    logic [PR_W-1:0]    pr_next [LANES];
    logic               neg_reg [LANES];
    logic               neg_next [LANES];
    coord_t             out_x_reg, out_x_next;
    coord_t             out_y_reg, out_y_next;
    dist_t              out_dist_reg, out_dist_next;

    // lane arithmetic
    logic [HI_W:0]           msum [LANES];
    logic [PR_W-1:0]         mul_step [LANES];
    logic [PR_W-1:0]         dsh [LANES];
    logic [HI_W-1:0]         dtop [LANES];
    logic [HI_W-1:0]         dsub [LANES];
    logic [PR_W-1:0]         div_step [LANES];
    mag_t                    absd [LANES];
    logic                    b_lt_a [LANES];
    logic                    q_lt_a [LANES];
    logic signed [DOT_W-1:0] sprod [LANES];
    logic [COORD_W:0]        qmag [LANES];
    logic [COORD_W:0]        qsgn [LANES];
    logic [COORD_W:0]        csum [LANES];
    dist_t                   psum;
    logic [OP_W-1:0]         launch;
    logic                    accept;

    assign accept       = query.valid && query.ready;
    assign query.ready  = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.closest_x   = out_x_reg;
    assign result.closest_y   = out_y_reg;
    assign result.min_dist_sq = out_dist_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            // multiply: add multiplicand on the low bit, shift right
            msum[i] = {1'b0, pr_reg[i][PR_W-1:MAG_W]}
                    + (pr_reg[i][0] ? {2'b0, opa_reg[i]} : '0);
            mul_step[i] = {msum[i], pr_reg[i][MAG_W-1:1]};
            // divide: shift left, subtract divisor when it fits, feed quotient bit
            dsh[i]  = {pr_reg[i][PR_W-2:0], 1'b0};
            dtop[i] = dsh[i][PR_W-1:MAG_W];
            dsub[i] = dtop[i] - {1'b0, opa_reg[i]};
            div_step[i] = (dtop[i] >= {1'b0, opa_reg[i]})
                        ? {dsub[i], dsh[i][MAG_W-1:1], 1'b1} : dsh[i];

            absd[i]   = abs_diff(b_reg[i], a_reg[i]);
            b_lt_a[i] = (b_reg[i] < a_reg[i]);
            q_lt_a[i] = (q_reg[i] < a_reg[i]);
            sprod[i]  = neg_reg[i] ? -$signed({2'b0, pr_reg[i][LEN_W-1:0]})
                                   : $signed({2'b0, pr_reg[i][LEN_W-1:0]});

            // floor of the projected offset: round the magnitude up when negative
            qmag[i] = {1'b0, pr_reg[i][MAG_W-1:0]}
                    + (COORD_W+1)'(|pr_reg[i][PR_W-1:MAG_W]);
            qsgn[i] = neg_reg[i] ? (~qmag[i] + 1'b1) : {1'b0, pr_reg[i][MAG_W-1:0]};
            csum[i] = {a_reg[i][COORD_W-1], a_reg[i]} + qsgn[i];
        end
        psum = {1'b0, pr_reg[0][LEN_W-1:0]} + {1'b0, pr_reg[1][LEN_W-1:0]};
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        div_next       = div_reg;
        out_valid_next = out_valid_reg;
        best_dist_next = best_dist_reg;
        present_next   = present_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        len2_next      = len2_reg;
        dot_next       = dot_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_dist_next  = out_dist_reg;
        launch         = OP_NONE;
        for (int i = 0; i < LANES; i++)
        begin
            seed_next[i] = seed_reg[i];
            best_next[i] = best_reg[i];
            q_next[i]    = q_reg[i];
            a_next[i]    = a_reg[i];
            b_next[i]    = b_reg[i];
            cand_next[i] = cand_reg[i];
            opa_next[i]  = opa_reg[i];
            neg_next[i]  = neg_reg[i];
            pr_next[i]   = pr_reg[i];
            if (cnt_reg != '0)
            begin
                pr_next[i] = div_reg ? div_step[i] : mul_step[i];
            end
        end
        if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SEED_X: seed_next[0] = coord_t'(cfg_data);
                REG_SEED_Y: seed_next[1] = coord_t'(cfg_data);
                default: ;
            endcase
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    q_next[0]    = query.query_x;
                    q_next[1]    = query.query_y;
                    a_next[0]    = query.edge_start_x;
                    a_next[1]    = query.edge_start_y;
                    b_next[0]    = query.edge_end_x;
                    b_next[1]    = query.edge_end_y;
                    present_next = query.edge_present;
                    first_next   = query.first_edge;
                    last_next    = query.last_edge;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                if (first_reg)
                begin
                    launch     = OP_SEED;
                    state_next = S_SEED;
                end
                else if (present_reg)
                begin
                    launch     = OP_LEN;
                    state_next = S_LEN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SEED:
            begin
                if (cnt_reg == '0)
                begin
                    best_next[0]   = seed_reg[0];
                    best_next[1]   = seed_reg[1];
                    best_dist_next = psum;
                    if (present_reg)
                    begin
                        launch     = OP_LEN;
                        state_next = S_LEN;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_LEN:
            begin
                if (cnt_reg == '0)
                begin
                    len2_next  = psum[LEN_W-1:0];
                    launch     = OP_DOT;
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                if (cnt_reg == '0)
                begin
                    dot_next   = sprod[0] + sprod[1];
                    state_next = S_CHOOSE;
                end
            end
            S_CHOOSE:
            begin
                // degenerate edge or behind the start: start point
                if (len2_reg == '0 || dot_reg[DOT_W-1])
                begin
                    cand_next[0] = a_reg[0];
                    cand_next[1] = a_reg[1];
                    state_next   = S_CAND;
                end
                else if (dot_reg > $signed({2'b0, len2_reg}))
                begin
                    cand_next[0] = b_reg[0];
                    cand_next[1] = b_reg[1];
                    state_next   = S_CAND;
                end
                else
                begin
                    launch     = OP_PROJ;
                    state_next = S_PROJ;
                end
            end
            S_PROJ:
            begin
                if (cnt_reg == '0)
                begin
                    launch     = OP_DIV;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    cand_next[0] = csum[0][COORD_W-1:0];
                    cand_next[1] = csum[1][COORD_W-1:0];
                    state_next   = S_CAND;
                end
            end
            S_CAND:
            begin
                launch     = OP_DIST;
                state_next = S_DIST;
            end
            S_DIST:
            begin
                if (cnt_reg == '0)
                begin
                    // strictly smaller only: ties keep the earlier point
                    if (psum < best_dist_reg)
                    begin
                        best_next[0]   = cand_reg[0];
                        best_next[1]   = cand_reg[1];
                        best_dist_next = psum;
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || result.ready)
                begin
                    out_x_next     = best_reg[0];
                    out_y_next     = best_reg[1];
                    out_dist_next  = best_dist_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // load the lane operands for the next pass
        if (launch != OP_NONE)
        begin
            cnt_next = CNT_W'(MAG_W);
            div_next = (launch == OP_DIV);
            for (int i = 0; i < LANES; i++)
            begin
                case (launch)
                    OP_SEED:
                    begin
                        opa_next[i] = LEN_W'(abs_diff(q_reg[i], seed_reg[i]));
                        pr_next[i]  = PR_W'(abs_diff(q_reg[i], seed_reg[i]));
                        neg_next[i] = 1'b0;
                    end
                    OP_LEN:
                    begin
                        opa_next[i] = LEN_W'(absd[i]);
                        pr_next[i]  = PR_W'(absd[i]);
                        neg_next[i] = 1'b0;
                    end
                    OP_DOT:
                    begin
                        opa_next[i] = LEN_W'(abs_diff(q_reg[i], a_reg[i]));
                        pr_next[i]  = PR_W'(absd[i]);
                        neg_next[i] = q_lt_a[i] ^ b_lt_a[i];
                    end
                    OP_PROJ:
                    begin
                        opa_next[i] = dot_reg[LEN_W-1:0];
                        pr_next[i]  = PR_W'(absd[i]);
                        neg_next[i] = b_lt_a[i];
                    end
                    OP_DIV:
                    begin
                        // product stays in place as the dividend
                        opa_next[i] = len2_reg;
                    end
                    OP_DIST:
                    begin
                        opa_next[i] = LEN_W'(abs_diff(q_reg[i], cand_reg[i]));
                        pr_next[i]  = PR_W'(abs_diff(q_reg[i], cand_reg[i]));
                        neg_next[i] = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            div_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            best_dist_reg <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                seed_reg[i] <= '0;
                best_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            div_reg       <= div_next;
            out_valid_reg <= out_valid_next;
            best_dist_reg <= best_dist_next;
            for (int i = 0; i < LANES; i++)
            begin
                seed_reg[i] <= seed_next[i];
                best_reg[i] <= best_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        present_reg  <= present_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        len2_reg     <= len2_next;
        dot_reg      <= dot_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_dist_reg <= out_dist_next;
        for (int i = 0; i < LANES; i++)
        begin
            q_reg[i]    <= q_next[i];
            a_reg[i]    <= a_next[i];
            b_reg[i]    <= b_next[i];
            cand_reg[i] <= cand_next[i];
            opa_reg[i]  <= opa_next[i];
            pr_reg[i]   <= pr_next[i];
            neg_reg[i]  <= neg_next[i];
        end
    end

    `CPES_ASSERT_IMP(a_result_from_fin, $rose(out_valid_reg),
        $past(state_reg == S_FIN && last_reg), "result raised outside the final step")
    `CPES_ASSERT_IMP(a_lanes_only_in_pass, cnt_reg != '0,
        state_reg == S_SEED || state_reg == S_LEN || state_reg == S_DOT ||
        state_reg == S_PROJ || state_reg == S_DIV || state_reg == S_DIST,
        "lane pass running outside a pass state")
    `CPES_ASSERT_IMP(a_proj_on_edge, state_reg == S_CAND && $past(state_reg) == S_DIV,
        (cand_reg[0] >= a_reg[0] && cand_reg[0] <= b_reg[0]) ||
        (cand_reg[0] <= a_reg[0] && cand_reg[0] >= b_reg[0]),
        "projected x left the edge span")
    `CPES_ASSERT_NXT(a_best_never_grows, state_reg == S_DIST && cnt_reg == '0,
        best_dist_reg <= $past(best_dist_reg), "edge compare raised the best distance")

endmodule
